// ===== rtl/core/crtcvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC vertical timing package
// Shared request codes, register numbers and the structures passed between
// the register file, the vertical counters and the top level.
// ----------------------------------------------------------------------------
package crtcvt_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_IDLE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FE_NONE    = 2'd0,
		FE_ADJUST  = 2'd1,
		FE_PENDING = 2'd2
	} fe_state_t;

	localparam logic [4:0] REG_SYNC_WIDTH   = 5'd3;
	localparam logic [4:0] REG_VTOTAL       = 5'd4;
	localparam logic [4:0] REG_VADJUST      = 5'd5;
	localparam logic [4:0] REG_VDISPLAYED   = 5'd6;
	localparam logic [4:0] REG_VSYNC_POS    = 5'd7;
	localparam logic [4:0] REG_MODE_CTRL    = 5'd8;
	localparam logic [4:0] REG_MAX_SCAN     = 5'd9;
	localparam logic [4:0] REG_CURSOR_START = 5'd10;
	localparam logic [4:0] REG_CURSOR_END   = 5'd11;
	localparam logic [4:0] REG_START_HI     = 5'd12;
	localparam logic [4:0] REG_START_LO     = 5'd13;
	localparam logic [4:0] REG_CURSOR_HI    = 5'd14;
	localparam logic [4:0] REG_CURSOR_LO    = 5'd15;
	localparam logic [4:0] REG_LPEN_HI      = 5'd16;
	localparam logic [4:0] REG_LPEN_LO      = 5'd17;

	localparam logic [7:0] LPEN_HI_VALUE = 8'h3F;
	localparam logic [7:0] LPEN_LO_VALUE = 8'hFF;

	// cursor blink mode, register 10 bits 6:5
	localparam logic [1:0] CURSOR_STEADY = 2'b00;
	localparam logic [1:0] CURSOR_OFF    = 2'b01;
	localparam logic [1:0] CURSOR_FAST   = 2'b10;
	localparam logic [1:0] CURSOR_SLOW   = 2'b11;

	localparam logic [4:0] ROW_MASK_NORMAL    = 5'h1F;
	localparam logic [4:0] ROW_MASK_INTERLACE = 5'h1E;

	typedef struct packed {
		logic        valid;
		mode_t       mode;
		logic [4:0]  addr;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic [3:0]  vsync_width;
		logic [6:0]  vtotal;
		logic [4:0]  vadjust;
		logic [6:0]  vdisp;
		logic [6:0]  vsync_pos;
		logic        interlace;
		logic [4:0]  max_scan;
		logic [6:0]  cursor_start;
		logic [4:0]  cursor_end;
		logic [13:0] start_addr;
	} vregs_t;

	typedef struct packed {
		logic        vsync;
		logic        vert_display;
		logic [4:0]  scan_row;
		logic [6:0]  char_row;
		logic [13:0] line_start;
		logic        cursor_on;
		logic        odd_field;
		logic        frame_start;
	} status_t;

endpackage

// ===== rtl/core/crtc_vertical_timing_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC vertical timing unit
// Vertical half of a 6845-style CRT controller: register writes, reads of
// registers 12 to 17 and line-end ticks, one result per request.
// ----------------------------------------------------------------------------
// Each request is held in the input register and its result is written to the
// output register once the output register can advance. A request can be
// accepted every cycle while the result side is not stalled; the next counter and
// register state is computed combinationally from the input register. A stalled
// result blocks the next request only while the input register is occupied.
module crtc_vertical_timing_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [4:0]  reg_addr,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        vsync,
	output logic        vert_display,
	output logic [4:0]  scan_row,
	output logic [6:0]  char_row,
	output logic [13:0] line_start_address,
	output logic        cursor_line_on,
	output logic        odd_field,
	output logic        frame_start
);
	import crtcvt_pkg::*;

	logic       valid_s1;
	mode_t      mode_s1;
	logic [4:0] addr_s1;
	logic [7:0] data_s1;
	logic       advance;
	logic       accept;
	logic       proc_s1;
	req_t       req;
	vregs_t     regs;
	logic [7:0] rd_data;
	status_t    status_d;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	status_t    status_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign proc_s1  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_t'(mode);
			addr_s1 <= reg_addr;
			data_s1 <= write_data;
		end
	end

	always_comb begin
		req.valid = proc_s1;
		req.mode  = mode_s1;
		req.addr  = addr_s1;
		req.data  = data_s1;
	end

	crtcvt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.regs    (regs),
		.rd_data (rd_data)
	);

	crtcvt_timing u_timing (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.regs     (regs),
		.status_d (status_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			read_data_q <= '0;
			status_q    <= '0;
		end else if (proc_s1) begin
			out_valid_q <= 1'b1;
			read_data_q <= rd_data;
			status_q    <= status_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid          = out_valid_q;
	assign read_data          = read_data_q;
	assign vsync              = status_q.vsync;
	assign vert_display       = status_q.vert_display;
	assign scan_row           = status_q.scan_row;
	assign char_row           = status_q.char_row;
	assign line_start_address = status_q.line_start;
	assign cursor_line_on     = status_q.cursor_on;
	assign odd_field          = status_q.odd_field;
	assign frame_start        = status_q.frame_start;

`ifndef NO_ASSERTIONS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 |=> out_valid_q)
		else $error("processed request produced no result");

	a_frame_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q.frame_start |-> status_q.char_row == 7'd0 &&
			status_q.scan_row[4:1] == 4'd0)
		else $error("frame start without row reset");

	a_field_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 |=> ((status_q.odd_field != $past(status_q.odd_field)) ==
			status_q.frame_start))
		else $error("field parity changed outside frame start");

	a_read_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 && mode_s1 != MODE_READ |=> read_data_q == 8'd0)
		else $error("read data on non-read request");
`endif

endmodule

// ===== rtl/core/crtcvt_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC vertical register file
// Holds the vertical timing, cursor and start address registers, applies the
// per-register write masks and returns read data for registers 12 to 17.
// ----------------------------------------------------------------------------
module crtcvt_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  crtcvt_pkg::req_t    req,
	output crtcvt_pkg::vregs_t  regs,
	output logic [7:0]          rd_data
);
	import crtcvt_pkg::*;

	logic [3:0] r3_hi_q;
	logic [6:0] r4_q;
	logic [4:0] r5_q;
	logic [6:0] r6_q;
	logic [6:0] r7_q;
	logic       interlace_q;
	logic [4:0] r9_q;
	logic [6:0] r10_q;
	logic [4:0] r11_q;
	logic [5:0] r12_q;
	logic [7:0] r13_q;
	logic [5:0] r14_q;
	logic [7:0] r15_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r3_hi_q     <= '0;
			r4_q        <= '0;
			r5_q        <= '0;
			r6_q        <= '0;
			r7_q        <= '0;
			interlace_q <= 1'b0;
			r9_q        <= '0;
			r10_q       <= '0;
			r11_q       <= '0;
			r12_q       <= '0;
			r13_q       <= '0;
			r14_q       <= '0;
			r15_q       <= '0;
		end else if (req.valid && req.mode == MODE_WRITE) begin
			case (req.addr)
				REG_SYNC_WIDTH:   r3_hi_q     <= req.data[7:4];
				REG_VTOTAL:       r4_q        <= req.data[6:0];
				REG_VADJUST:      r5_q        <= req.data[4:0];
				REG_VDISPLAYED:   r6_q        <= req.data[6:0];
				REG_VSYNC_POS:    r7_q        <= req.data[6:0];
				REG_MODE_CTRL:    interlace_q <= &req.data[1:0];
				REG_MAX_SCAN:     r9_q        <= req.data[4:0];
				REG_CURSOR_START: r10_q       <= req.data[6:0];
				REG_CURSOR_END:   r11_q       <= req.data[4:0];
				REG_START_HI:     r12_q       <= req.data[5:0];
				REG_START_LO:     r13_q       <= req.data;
				REG_CURSOR_HI:    r14_q       <= req.data[5:0];
				REG_CURSOR_LO:    r15_q       <= req.data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		regs.vsync_width  = r3_hi_q;
		regs.vtotal       = r4_q;
		regs.vadjust      = r5_q;
		regs.vdisp        = r6_q;
		regs.vsync_pos    = r7_q;
		regs.interlace    = interlace_q;
		regs.max_scan     = r9_q;
		regs.cursor_start = r10_q;
		regs.cursor_end   = r11_q;
		regs.start_addr   = {r12_q, r13_q};
	end

	always_comb begin
		rd_data = '0;
		if (req.mode == MODE_READ) begin
			case (req.addr)
				REG_START_HI:  rd_data = {2'b00, r12_q};
				REG_START_LO:  rd_data = r13_q;
				REG_CURSOR_HI: rd_data = {2'b00, r14_q};
				REG_CURSOR_LO: rd_data = r15_q;
				REG_LPEN_HI:   rd_data = LPEN_HI_VALUE;
				REG_LPEN_LO:   rd_data = LPEN_LO_VALUE;
				default:       rd_data = '0;
			endcase
		end
	end

endmodule

// ===== rtl/core/crtcvt_timing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC vertical counters
// Scan row, character row, adjust, field, start address, cursor line, flash
// and vsync state. Computes the state after one request.
// ----------------------------------------------------------------------------
module crtcvt_timing (
	input  logic                clk,
	input  logic                arst_n,
	input  crtcvt_pkg::req_t    req,
	input  crtcvt_pkg::vregs_t  regs,
	output crtcvt_pkg::status_t status_d
);
	import crtcvt_pkg::*;

	logic        vde_q,  vde_d;
	logic        vs_q,   vs_d;
	logic [3:0]  vc_q,   vc_d;
	logic [4:0]  sc_q,   sc_d;
	logic [6:0]  rc_q,   rc_d;
	logic        fp_q,   fp_d;
	logic [13:0] sa_q,   sa_d;
	logic [13:0] sal_q,  sal_d;
	logic [1:0]  cf_q,   cf_d;
	logic [4:0]  fc_q,   fc_d;
	fe_state_t   fes_q,  fes_d;
	logic [4:0]  al_q,   al_d;
	logic [4:0]  m;
	logic        new_frame;

	function automatic logic [4:0] row_base(input logic il, input logic par);
		return il ? {4'b0000, par} : 5'b00000;
	endfunction

	always_comb begin
		m         = regs.interlace ? ROW_MASK_INTERLACE : ROW_MASK_NORMAL;
		vde_d     = vde_q;
		vs_d      = vs_q;
		vc_d      = vc_q;
		sc_d      = sc_q;
		rc_d      = rc_q;
		fp_d      = fp_q;
		sa_d      = sa_q;
		sal_d     = sal_q;
		cf_d      = cf_q;
		fc_d      = fc_q;
		fes_d     = fes_q;
		al_d      = al_q;
		new_frame = 1'b0;

		if (req.valid && req.mode == MODE_WRITE) begin
			if (req.addr == REG_VDISPLAYED && req.data[6:0] == rc_q)
				vde_d = 1'b0;
			if (req.addr == REG_VSYNC_POS && req.data[6:0] == rc_q &&
			    regs.vsync_pos != rc_q) begin
				vs_d = 1'b1;
				vc_d = '0;
			end
		end

		if (req.valid && req.mode == MODE_TICK) begin
			sa_d = sal_q;
			if (((sc_q ^ regs.cursor_end) & m) == 5'd0)
				cf_d[0] = 1'b1;

			if (fes_q == FE_PENDING) begin
				fes_d = FE_ADJUST;
				sc_d  = row_base(regs.interlace, fp_q);
				rc_d  = rc_q + 7'd1;
				if ((al_q & m) != 5'd0)
					al_d = regs.vadjust;
				else
					new_frame = 1'b1;
			end else if (fes_q != FE_NONE) begin
				sc_d = sc_q - m;
				if (((sc_d ^ al_q) & m) != 5'd0)
					al_d = regs.vadjust;
				else
					new_frame = 1'b1;
			end else if (((sc_q ^ regs.max_scan) & m) == 5'd0) begin
				sc_d = row_base(regs.interlace, fp_q);
				rc_d = rc_q + 7'd1;
				if (rc_d == 7'd0) begin
					sa_d  = regs.start_addr;
					sal_d = regs.start_addr;
				end
			end else begin
				sc_d = sc_q - m;
				if (rc_q == regs.vtotal && ((sc_d ^ regs.max_scan) & m) == 5'd0) begin
					fes_d = FE_PENDING;
					al_d  = regs.vadjust;
				end
			end

			if (new_frame) begin
				fes_d = FE_NONE;
				vde_d = 1'b1;
				vs_d  = 1'b0;
				vc_d  = '0;
				fp_d  = ~fp_q;
				sc_d  = row_base(regs.interlace, ~fp_q);
				rc_d  = '0;
				if (regs.vtotal == 7'd0 && (regs.max_scan & m) == 5'd0) begin
					fes_d = FE_PENDING;
					al_d  = regs.vadjust;
				end
				sa_d  = regs.start_addr;
				sal_d = regs.start_addr;
				fc_d  = fc_q + 5'd1;
				unique case (regs.cursor_start[6:5])
					CURSOR_STEADY: cf_d = 2'b01;
					CURSOR_OFF:    cf_d = 2'b11;
					CURSOR_FAST:   cf_d = {fc_d[3], 1'b1};
					CURSOR_SLOW:   cf_d = {fc_d[4], 1'b1};
				endcase
			end

			if (((sc_d ^ regs.cursor_start[4:0]) & m) == 5'd0)
				cf_d[0] = 1'b0;

			if (vs_d) begin
				vc_d = vc_d + 4'd1;
				if (vc_d == regs.vsync_width)
					vs_d = 1'b0;
			end
			if (rc_d == regs.vdisp)
				vde_d = 1'b0;
			if (rc_d == regs.vsync_pos && (sc_d & m) == 5'd0) begin
				vs_d = 1'b1;
				vc_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vde_q <= 1'b0;
			vs_q  <= 1'b0;
			vc_q  <= '0;
			sc_q  <= '0;
			rc_q  <= '0;
			fp_q  <= 1'b0;
			sa_q  <= '0;
			sal_q <= '0;
			cf_q  <= 2'b11;
			fc_q  <= '0;
			fes_q <= FE_NONE;
			al_q  <= '0;
		end else begin
			vde_q <= vde_d;
			vs_q  <= vs_d;
			vc_q  <= vc_d;
			sc_q  <= sc_d;
			rc_q  <= rc_d;
			fp_q  <= fp_d;
			sa_q  <= sa_d;
			sal_q <= sal_d;
			cf_q  <= cf_d;
			fc_q  <= fc_d;
			fes_q <= fes_d;
			al_q  <= al_d;
		end
	end

	always_comb begin
		status_d.vsync        = vs_d;
		status_d.vert_display = vde_d;
		status_d.scan_row     = sc_d;
		status_d.char_row     = rc_d;
		status_d.line_start   = sa_d;
		status_d.cursor_on    = (cf_d == 2'b00);
		status_d.odd_field    = fp_d;
		status_d.frame_start  = new_frame;
	end

endmodule

// ===== tb/sv/crtc_vertical_timing_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC vertical timing checker
// Watches both request and result channels of the vertical timing unit. Every
// accepted request is run through a local model of the register file and the
// vertical counters. Each accepted result is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module crtc_vertical_timing_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [4:0]  reg_addr,
	input  logic [7:0]  write_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  read_data,
	input  logic        vsync,
	input  logic        vert_display,
	input  logic [4:0]  scan_row,
	input  logic [6:0]  char_row,
	input  logic [13:0] line_start_address,
	input  logic        cursor_line_on,
	input  logic        odd_field,
	input  logic        frame_start,
	output int          mismatches,
	output int          pending,
	output int          compared,
	output int          frames
);
	import crtcvt_pkg::*;

	typedef struct packed {
		logic [7:0] rd;
		status_t    st;
	} line_result_t;

	// local copy of the controller state
	logic [7:0]  regs [0:17];
	logic [6:0]  row_q;
	logic [4:0]  scan_q;
	logic        parity_q;
	logic [13:0] addr_q;
	logic [13:0] addr_latch_q;
	logic [1:0]  cursor_q;
	logic [7:0]  flash_q;
	fe_state_t   fe_q;
	logic [4:0]  adj_q;
	logic        vs_q;
	logic [3:0]  vcnt_q;
	logic [2:0]  disp_q;
	logic        ilace_q;

	line_result_t outstanding [$];
	line_result_t want;
	line_result_t fresh;
	logic         began;
	logic [7:0]   rd;

	function automatic logic [4:0] scan_mask();
		return ilace_q ? ROW_MASK_INTERLACE : ROW_MASK_NORMAL;
	endfunction

	function automatic logic [4:0] scan_base();
		return ilace_q ? {4'd0, parity_q} : 5'd0;
	endfunction

	function automatic logic [13:0] programmed_start();
		return {regs[REG_START_HI][5:0], regs[REG_START_LO]};
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	task automatic clear_prediction();
		for (int i = 0; i < 18; i++)
			regs[i] = 8'h00;
		regs[REG_LPEN_HI] = LPEN_HI_VALUE;
		regs[REG_LPEN_LO] = LPEN_LO_VALUE;
		ilace_q = 1'b0;
		disp_q = 3'd0;
		vs_q = 1'b0;
		vcnt_q = 4'd0;
		scan_q = 5'd0;
		row_q = 7'd0;
		parity_q = 1'b0;
		addr_q = programmed_start();
		addr_latch_q = addr_q;
		cursor_q = 2'b11;
		flash_q = 8'd0;
		fe_q = FE_NONE;
		adj_q = regs[REG_VADJUST][4:0];
	endtask

	// end of total rows / adjust lines; began is set when a new frame starts
	task automatic close_frame(output logic new_frame);
		logic [4:0] m;
		m = scan_mask();
		new_frame = 1'b1;
		if (fe_q == FE_PENDING) begin
			fe_q = FE_ADJUST;
			scan_q = scan_base();
			row_q = row_q + 7'd1;
			if ((adj_q & m) != 5'd0) begin
				adj_q = regs[REG_VADJUST][4:0];
				new_frame = 1'b0;
			end
		end else begin
			scan_q = scan_q - m;
			if (((scan_q ^ adj_q) & m) != 5'd0) begin
				adj_q = regs[REG_VADJUST][4:0];
				new_frame = 1'b0;
			end
		end
		if (new_frame) begin
			fe_q = FE_NONE;
			disp_q = 3'd7;
			vs_q = 1'b0;
			vcnt_q = 4'd0;
			parity_q = ~parity_q;
			scan_q = scan_base();
			row_q = 7'd0;
			if ((regs[REG_VTOTAL] | (regs[REG_MAX_SCAN] & {3'd0, m})) == 8'd0) begin
				fe_q = FE_PENDING;
				adj_q = regs[REG_VADJUST][4:0];
			end
			addr_q = programmed_start();
			addr_latch_q = addr_q;
			flash_q = flash_q + 8'd1;
			case (regs[REG_CURSOR_START][6:5])
				CURSOR_STEADY: cursor_q = 2'b01;
				CURSOR_OFF:    cursor_q = 2'b11;
				CURSOR_FAST:   cursor_q = {flash_q[3], 1'b1};
				default:       cursor_q = {flash_q[4], 1'b1};
			endcase
		end
	endtask

	task automatic advance_line(output logic new_frame);
		logic [4:0] m;
		m = scan_mask();
		new_frame = 1'b0;
		disp_q = disp_q | 3'b010 | {2'b00, disp_q[2]};
		addr_q = addr_latch_q;
		if (((scan_q ^ regs[REG_CURSOR_END][4:0]) & m) == 5'd0)
			cursor_q[0] = 1'b1;
		if (fe_q != FE_NONE) begin
			close_frame(new_frame);
		end else if (((scan_q ^ regs[REG_MAX_SCAN][4:0]) & m) == 5'd0) begin
			scan_q = scan_base();
			row_q = row_q + 7'd1;
			if (row_q == 7'd0) begin
				addr_q = programmed_start();
				addr_latch_q = addr_q;
			end
		end else begin
			scan_q = scan_q - m;
			if ({1'b0, row_q} == regs[REG_VTOTAL] &&
					((scan_q ^ regs[REG_MAX_SCAN][4:0]) & m) == 5'd0) begin
				fe_q = FE_PENDING;
				adj_q = regs[REG_VADJUST][4:0];
			end
		end
		if (((scan_q ^ regs[REG_CURSOR_START][4:0]) & m) == 5'd0)
			cursor_q[0] = 1'b0;
		if (vs_q) begin
			vcnt_q = vcnt_q + 4'd1;
			if (vcnt_q == regs[REG_SYNC_WIDTH][7:4])
				vs_q = 1'b0;
		end
		if ({1'b0, row_q} == regs[REG_VDISPLAYED])
			disp_q = 3'b010;
		if ({1'b0, row_q} == regs[REG_VSYNC_POS] && (scan_q & m) == 5'd0) begin
			vs_q = 1'b1;
			vcnt_q = 4'd0;
		end
	endtask

	task automatic store_register(input logic [4:0] a, input logic [7:0] v);
		logic [7:0] val;
		val = v;
		if (a < REG_LPEN_HI) begin
			case (a)
				REG_VTOTAL:       val = val & 8'h7F;
				REG_VADJUST:      val = val & 8'h1F;
				REG_VDISPLAYED: begin
					val = val & 8'h7F;
					if (val == {1'b0, row_q})
						disp_q = disp_q & 3'b010;
				end
				REG_VSYNC_POS: begin
					val = val & 8'h7F;
					if (val == {1'b0, row_q} && regs[REG_VSYNC_POS] != {1'b0, row_q}) begin
						vs_q = 1'b1;
						vcnt_q = 4'd0;
					end
				end
				REG_MODE_CTRL: begin
					val = val & 8'hF3;
					ilace_q = (val[1:0] == 2'b11);
				end
				REG_MAX_SCAN:     val = val & 8'h1F;
				REG_CURSOR_START: val = val & 8'h7F;
				REG_CURSOR_END:   val = val & 8'h1F;
				REG_START_HI:     val = val & 8'h3F;
				REG_CURSOR_HI:    val = val & 8'h3F;
				default: ;
			endcase
			regs[a] = val;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_prediction();
			outstanding.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outstanding.size() == 0) begin
					report_mismatch("result with no request outstanding", 1, 0);
				end else begin
					want = outstanding.pop_front();
					if (read_data != want.rd)
						report_mismatch("read_data", int'(read_data), int'(want.rd));
					if (vsync != want.st.vsync)
						report_mismatch("vsync", int'(vsync), int'(want.st.vsync));
					if (vert_display != want.st.vert_display)
						report_mismatch("vert_display", int'(vert_display),
							int'(want.st.vert_display));
					if (scan_row != want.st.scan_row)
						report_mismatch("scan_row", int'(scan_row), int'(want.st.scan_row));
					if (char_row != want.st.char_row)
						report_mismatch("char_row", int'(char_row), int'(want.st.char_row));
					if (line_start_address != want.st.line_start)
						report_mismatch("line_start_address", int'(line_start_address),
							int'(want.st.line_start));
					if (cursor_line_on != want.st.cursor_on)
						report_mismatch("cursor_line_on", int'(cursor_line_on),
							int'(want.st.cursor_on));
					if (odd_field != want.st.odd_field)
						report_mismatch("odd_field", int'(odd_field), int'(want.st.odd_field));
					if (frame_start != want.st.frame_start)
						report_mismatch("frame_start", int'(frame_start),
							int'(want.st.frame_start));
					compared++;
				end
			end
			if (in_valid && !in_stall) begin
				began = 1'b0;
				rd = 8'h00;
				case (mode)
					MODE_WRITE: store_register(reg_addr, write_data);
					MODE_READ: begin
						if (reg_addr >= REG_START_HI && reg_addr <= REG_LPEN_LO)
							rd = regs[reg_addr];
					end
					MODE_TICK: advance_line(began);
					default: ;
				endcase
				if (began)
					frames++;
				fresh.rd = rd;
				fresh.st.vsync = vs_q;
				fresh.st.vert_display = disp_q[2];
				fresh.st.scan_row = scan_q;
				fresh.st.char_row = row_q;
				fresh.st.line_start = addr_q;
				fresh.st.cursor_on = (cursor_q == 2'b00);
				fresh.st.odd_field = parity_q;
				fresh.st.frame_start = began;
				outstanding.push_back(fresh);
			end
			pending = outstanding.size();
		end
	end

endmodule

// ===== tb/sv/crtc_vertical_timing_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRTC vertical timing unit testbench
// Drives register writes, reads and line-end ticks into the unit with random
// gaps and result back-pressure, including at least one long receiver hold-off. Short
// frame settings dominate so that frames, vsync, cursor and interlace paths
// are exercised often; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module crtc_vertical_timing_unit_test;
	import crtcvt_pkg::*;

	localparam int ITEM_TARGET = 1050;
	localparam int IDLE_PCT = 22;
	localparam int HOLD_CYCLES = 80;
	localparam logic [4:0] LAST_REG_ADDR = 5'd31;

	typedef enum int {
		SET_RANDOM,
		SET_ZEROS,
		SET_ONES
	} setting_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [4:0]  reg_addr;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        vsync;
	logic        vert_display;
	logic [4:0]  scan_row;
	logic [6:0]  char_row;
	logic [13:0] line_start_address;
	logic        cursor_line_on;
	logic        odd_field;
	logic        frame_start;

	int mismatches;
	int pending;
	int compared;
	int frames;

	int send_idle_pct = IDLE_PCT;
	int recv_stall_pct = IDLE_PCT;
	bit hold_off_request = 1'b0;
	int items_sent = 0;
	int writes_sent = 0;
	int reads_sent = 0;
	int ticks_sent = 0;
	int ignored_sent = 0;

	bit big_pick;
	bit lace_pick;

	crtc_vertical_timing_unit uut (.*);

	crtc_vertical_timing_checker watch (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("crtc_vertical_timing_unit_test: done, errors");
		$finish;
	end

	// result side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_request = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_request(input mode_t m, input logic [4:0] a, input logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		reg_addr <= a;
		write_data <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		case (m)
			MODE_WRITE: begin
				if (a >= REG_LPEN_HI)
					ignored_sent++;
				else
					writes_sent++;
			end
			MODE_READ: reads_sent++;
			MODE_TICK: ticks_sent++;
			default:   ignored_sent++;
		endcase
		if (!(m == MODE_IDLE || (m == MODE_WRITE && a >= REG_LPEN_HI)))
			items_sent++;
	endtask

	task automatic tick_lines(input int n);
		repeat (n)
			send_request(MODE_TICK, 5'($urandom_range(31)), 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] reg_value(input logic [4:0] a, input setting_t flavour);
		logic [7:0] v;
		v = 8'($urandom_range(255));
		if (flavour == SET_ZEROS) begin
			v = 8'h00;
		end else if (flavour == SET_ONES) begin
			v = 8'hFF;
		end else if (!big_pick) begin
			case (a)
				REG_VTOTAL:     v = 8'($urandom_range(6));
				REG_VADJUST:    v = 8'($urandom_range(3));
				REG_VDISPLAYED: v = 8'($urandom_range(7));
				REG_VSYNC_POS:  v = 8'($urandom_range(7));
				REG_MAX_SCAN:   v = lace_pick ? 8'($urandom_range(5)) : 8'($urandom_range(3));
				REG_CURSOR_START, REG_CURSOR_END: v[4:0] = 5'($urandom_range(5));
				default: ;
			endcase
		end
		if (flavour == SET_RANDOM && a == REG_MODE_CTRL)
			v[1:0] = lace_pick ? 2'b11 : 2'($urandom_range(2));
		return v;
	endfunction

	initial begin
		int n;
		int r;
		int phase;
		setting_t flavour;
		logic [4:0] a;
		logic [7:0] d;

		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_IDLE;
		reg_addr = 5'd0;
		write_data = 8'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values, read window edges, ignored requests
		send_request(MODE_READ, REG_LPEN_HI, 8'h00);
		send_request(MODE_READ, REG_LPEN_LO, 8'hFF);
		send_request(MODE_READ, REG_START_HI, 8'h00);
		send_request(MODE_READ, REG_VADJUST, 8'h00);
		send_request(MODE_IDLE, LAST_REG_ADDR, 8'hFF);
		send_request(MODE_WRITE, REG_START_HI, 8'hFF);
		send_request(MODE_WRITE, REG_START_LO, 8'hFF);
		send_request(MODE_WRITE, REG_CURSOR_HI, 8'hFF);
		send_request(MODE_WRITE, REG_CURSOR_LO, 8'h00);
		send_request(MODE_READ, REG_START_HI, 8'h00);
		send_request(MODE_READ, REG_START_LO, 8'h00);
		send_request(MODE_READ, REG_CURSOR_HI, 8'h00);
		send_request(MODE_READ, REG_CURSOR_LO, 8'h00);
		send_request(MODE_WRITE, REG_LPEN_HI, 8'h12);
		send_request(MODE_WRITE, LAST_REG_ADDR, 8'hAA);
		send_request(MODE_READ, LAST_REG_ADDR, 8'h00);
		send_request(MODE_READ, REG_LPEN_HI, 8'h00);
		tick_lines(3);
		send_request(MODE_WRITE, REG_MODE_CTRL, 8'hFF);
		tick_lines(3);
		send_request(MODE_WRITE, REG_MODE_CTRL, 8'h00);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 7) begin
				// row passes total, so the character row wraps to zero
				send_request(MODE_WRITE, REG_MODE_CTRL, 8'h00);
				send_request(MODE_WRITE, REG_MAX_SCAN, 8'h00);
				send_request(MODE_WRITE, REG_VADJUST, 8'h00);
				send_request(MODE_WRITE, REG_SYNC_WIDTH, 8'h30);
				send_request(MODE_WRITE, REG_VDISPLAYED, 8'h50);
				send_request(MODE_WRITE, REG_VSYNC_POS, 8'h60);
				send_request(MODE_WRITE, REG_VTOTAL, 8'h7F);
				tick_lines(8);
				send_request(MODE_WRITE, REG_VTOTAL, 8'h02);
				tick_lines(135);
			end else begin
				flavour = (phase == 1) ? SET_ZEROS : (phase == 2) ? SET_ONES : SET_RANDOM;
				big_pick = ($urandom_range(9) == 0);
				lace_pick = ($urandom_range(99) < 30);
				for (int i = 0; i <= REG_CURSOR_LO; i++)
					send_request(MODE_WRITE, i[4:0], reg_value(i[4:0], flavour));
				if (phase == 5) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				if (phase == 3 || phase == 10)
					hold_off_request = 1'b1;
				n = $urandom_range(90, 50);
				repeat (n) begin
					r = $urandom_range(99);
					if (r < 72) begin
						tick_lines(1);
					end else if (r < 82) begin
						a = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) :
							5'($urandom_range(17, 12));
						send_request(MODE_READ, a, 8'($urandom_range(255)));
					end else if (r < 96) begin
						a = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) :
							5'($urandom_range(11, 3));
						d = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
						send_request(MODE_WRITE, a, d);
					end else begin
						send_request(MODE_IDLE, 5'($urandom_range(31)), 8'($urandom_range(255)));
					end
				end
				send_idle_pct = IDLE_PCT;
				recv_stall_pct = IDLE_PCT;
			end
			phase++;
		end

		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);

		$display("covered %0d requests in %0d phases: %0d writes, %0d reads, %0d line ticks, %0d ignored",
			items_sent, phase, writes_sent, reads_sent, ticks_sent, ignored_sent);
		$display("%0d results compared, %0d frame starts seen", compared, frames);
		if (mismatches == 0)
			$display("crtc_vertical_timing_unit_test: done, clean");
		else
			$display("crtc_vertical_timing_unit_test: done, errors");
		$finish;
	end

endmodule
